[sv/jsfe_pkg.sv]
// Shared types and constants for the JSON string field extractor.
// Used by jsfe_key_window, jsfe_parser and json_string_field_extractor_unit.
// No dependencies.
`default_nettype none

package jsfe_pkg;

    // Parse phase of the current line.
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SPACES,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Character codes.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    // Configuration register indexes.
    localparam logic REG_KEY_CHARS  = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    // Reset values of the configuration registers: key "message", length 7.
    localparam logic [63:0] KEY_CHARS_RESET  = 64'h0065_6761_7373_656D;
    localparam logic [3:0]  KEY_LENGTH_RESET = 4'd7;

    // Control from the parser to the key window.
    typedef struct packed {
        logic shift;
        logic clear;
    } window_ctrl_t;

    // One result of the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] value_byte;
        logic       value_end;
        logic       value_good;
    } result_t;

endpackage

`default_nettype wire

[sv/jsfe_key_window.sv]
// Sliding byte window and quoted-key comparator.
// Depends on jsfe_pkg.
`default_nettype none

module jsfe_key_window
    import jsfe_pkg::*;
#(
    parameter int MAX_KEY_CHARS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire window_ctrl_t         ctrl,
    input  wire logic [7:0]           data_byte,
    input  wire logic [63:0]          key_chars,
    input  wire logic [3:0]           key_length,
    output logic                      hit
);

    localparam int WinDepth = MAX_KEY_CHARS + 2;

    logic [7:0] win_reg  [WinDepth];
    logic [7:0] win_next [WinDepth];
    logic [3:0] len_eff;

    // Shift the newest byte in at position zero; clear at line end.
    always_comb
    begin
        for (int i = 0; i < WinDepth; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.clear)
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                win_next[i] = 8'h00;
            end
        end
        else if (ctrl.shift)
        begin
            win_next[0] = data_byte;
            for (int i = 1; i < WinDepth; i++)
            begin
                win_next[i] = win_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                win_reg[i] <= 8'h00;
            end
        end
        else
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Key length in use: zero counts as one, larger values saturate.
    always_comb
    begin
        if (key_length == 4'd0)
        begin
            len_eff = 4'd1;
        end
        else if (key_length > 4'(MAX_KEY_CHARS))
        begin
            len_eff = 4'(MAX_KEY_CHARS);
        end
        else
        begin
            len_eff = key_length;
        end
    end

    // Compare the shifted window against the quoted key for every length.
    always_comb
    begin
        logic m;
        hit = 1'b0;
        for (int l = 1; l <= MAX_KEY_CHARS; l++)
        begin
            m = (win_next[0] == CH_QUOTE) && (win_next[l + 1] == CH_QUOTE);
            for (int k = 0; k < MAX_KEY_CHARS; k++)
            begin
                if (k < l)
                begin
                    m = m && (win_next[l - k] == key_chars[8 * k +: 8]);
                end
            end
            if (len_eff == 4'(l))
            begin
                hit = m;
            end
        end
    end

endmodule

`default_nettype wire

[sv/jsfe_parser.sv]
// Per-line parse state machine: phase, escape flag and line byte count.
// Depends on jsfe_pkg.
`default_nettype none

module jsfe_parser
    import jsfe_pkg::*;
#(
    parameter int LINE_CAPACITY = 2048
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   data_byte,
    input  wire logic         end_of_stream,
    input  wire logic         hit,
    output window_ctrl_t      win_ctrl,
    output result_t           result
);

    localparam int CountWidth = $clog2(LINE_CAPACITY);

    phase_t                phase_reg, phase_next;
    logic                  esc_reg, esc_next;
    logic [CountWidth-1:0] count_reg, count_next;

    logic line_end;
    logic full;
    logic take;

    assign line_end = end_of_stream || (data_byte == CH_LF);
    assign full     = (count_reg == CountWidth'(LINE_CAPACITY - 1));
    // A stored, non-zero byte of the line.
    assign take     = step && !line_end && !full && (data_byte != CH_NUL);

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        if (step && line_end)
        begin
            phase_next = PH_SEARCH;
            esc_next   = 1'b0;
            count_next = '0;
        end
        else if (step && !full)
        begin
            count_next = count_reg + 1'b1;
            if (data_byte == CH_NUL)
            begin
                phase_next = PH_DONE;
                esc_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (hit)
                        begin
                            phase_next = PH_COLON;
                        end
                    end
                    PH_COLON:
                    begin
                        if (data_byte == CH_COLON)
                        begin
                            phase_next = PH_SPACES;
                        end
                    end
                    PH_SPACES:
                    begin
                        if (data_byte == CH_QUOTE)
                        begin
                            phase_next = PH_VALUE;
                        end
                        else if (data_byte != CH_SPACE && data_byte != CH_TAB)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                        end
                        else if (data_byte == CH_BACKSLASH)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (data_byte == CH_QUOTE)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            esc_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
        end
    end

    // Outputs: window control and the result of this byte.
    always_comb
    begin
        win_ctrl.clear    = step && line_end;
        win_ctrl.shift    = take && (phase_reg == PH_SEARCH);
        result.valid      = 1'b0;
        result.value_byte = 8'h00;
        result.value_end  = 1'b0;
        result.value_good = 1'b0;
        if (phase_reg == PH_VALUE && step)
        begin
            if (line_end || (!full && data_byte == CH_NUL))
            begin
                // Aborted end marker.
                result.valid     = 1'b1;
                result.value_end = 1'b1;
            end
            else if (take)
            begin
                if (esc_reg)
                begin
                    result.valid = 1'b1;
                    if (data_byte == CH_LOWER_N)
                    begin
                        result.value_byte = CH_LF;
                    end
                    else if (data_byte == CH_LOWER_T)
                    begin
                        result.value_byte = CH_TAB;
                    end
                    else
                    begin
                        result.value_byte = data_byte;
                    end
                end
                else if (data_byte == CH_QUOTE)
                begin
                    result.valid      = 1'b1;
                    result.value_end  = 1'b1;
                    result.value_good = 1'b1;
                end
                else if (data_byte != CH_BACKSLASH)
                begin
                    result.valid      = 1'b1;
                    result.value_byte = data_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/json_string_field_extractor_unit.sv]
// Top level of the JSON string field extractor: config registers, input and
// result registers. Depends on jsfe_pkg, jsfe_key_window and jsfe_parser.
//
//  Channel  Direction  Signals                            Content
//  s_*      in         s_tvalid s_tready s_tdata s_tlast  line bytes, tlast = end of stream
//  m_*      out        m_tvalid m_tready m_tdata m_tlast  value bytes, tlast = end marker
//  m_tuser  out        m_tuser                            good flag on end marker
//  cfg_*    in         cfg_we cfg_index cfg_data          key characters and key length
//
// One beat per cycle is accepted while s_tready is high. A beat is registered in
// the input register at its accepting edge and parsed from there; its result, if
// any, is loaded into the result register, which drives m_tvalid.
// Reset clears all parse state and loads the key "message" with length 7.
// A stalled result register holds the parse stage, and the input register
// then fills and drops s_tready.
`default_nettype none

module json_string_field_extractor_unit
    import jsfe_pkg::*;
#(
    parameter int LINE_CAPACITY = 2048,
    parameter int MAX_KEY_CHARS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic        s_tlast,    // end_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] value_byte
    output logic             m_tlast,    // value_end
    output logic [0:0]       m_tuser,    // [0] value_good
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] key_chars_reg;
    logic [3:0]  key_length_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eos_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_good_reg;

    logic         advance;
    logic         step;
    logic         hit;
    window_ctrl_t win_ctrl;
    result_t      result;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= KEY_CHARS_RESET;
            key_length_reg <= KEY_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_CHARS:  key_chars_reg  <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                default:        key_chars_reg  <= key_chars_reg;
            endcase
        end
    end

    // Handshake: parse stage moves when the result register is free.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    jsfe_key_window #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_key_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .data_byte  (in_byte_reg),
        .key_chars  (key_chars_reg),
        .key_length (key_length_reg),
        .hit        (hit)
    );

    jsfe_parser #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .hit           (hit),
        .win_ctrl      (win_ctrl),
        .result        (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            out_byte_reg <= result.value_byte;
            out_end_reg  <= result.value_end;
            out_good_reg <= result.value_good;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_end_reg;
    assign m_tuser[0] = out_good_reg;

endmodule

`default_nettype wire

[tb/sv/json_string_field_extractor_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for json_string_field_extractor_unit. It streams JSON-like
// lines and checks every value beat against a line parser kept inside the bench.
// Depends on jsfe_pkg and the json_string_field_extractor_unit RTL.

module json_string_field_extractor_unit_test;
    import jsfe_pkg::*;

    localparam int LINE_CAP      = 2048;
    localparam int KEY_MAX       = 8;
    localparam int WIN_DEPTH     = KEY_MAX + 2;
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_BEATS  = 800;

    // One value beat as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       good;
    } value_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    // Register copies and per-line parse state of the bench parser.
    logic [63:0] key_chars_q;
    logic [3:0]  key_len_q;
    logic [7:0]  recent_bytes [WIN_DEPTH];
    phase_t      line_phase;
    int          line_bytes;
    logic        esc_seen;

    // Value beats still to come from the block, oldest first.
    value_beat_t value_fifo [$];
    value_beat_t want;
    logic [7:0]  line_buf [$];

    int errors;
    int beats_in;
    int bytes_out;
    int good_ends;
    int aborted_ends;
    int ready_low_cycles;
    bit idle_on;
    int rx_hold;

    json_string_field_extractor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("** json_string_field_extractor_unit: FAILED **");
        $finish;
    end

    // Effective key length: zero counts as one, large values saturate.
    function automatic int key_span();
        if (key_len_q == 4'd0)
            return 1;
        if (key_len_q > KEY_MAX)
            return KEY_MAX;
        return key_len_q;
    endfunction

    function automatic logic [7:0] key_char(input int k);
        return key_chars_q[8*k +: 8];
    endfunction

    // True when the window holds the key wrapped in quotes.
    function automatic bit key_in_window();
        int n;
        bit hit;
        n   = key_span();
        hit = (recent_bytes[0] == CH_QUOTE) && (recent_bytes[n+1] == CH_QUOTE);
        for (int k = 0; k < n; k++)
            if (recent_bytes[n-k] != key_char(k))
                hit = 1'b0;
        return hit;
    endfunction

    function automatic void clear_line_state();
        foreach (recent_bytes[i])
            recent_bytes[i] = 8'h00;
        line_phase = PH_SEARCH;
        line_bytes = 0;
        esc_seen   = 1'b0;
    endfunction

    function automatic void push_value(input logic [7:0] b, input logic l, input logic g);
        value_fifo.push_back('{data: b, last: l, good: g});
    endfunction

    // Advance the bench parser by one accepted input beat.
    function automatic void parse_beat(input logic [7:0] b, input logic eos);
        if (eos || b == CH_LF)
        begin
            if (line_phase == PH_VALUE)
                push_value(8'h00, 1'b1, 1'b0);
            clear_line_state();
            return;
        end
        // Bytes past the line capacity are dropped unseen.
        if (line_bytes + 1 >= LINE_CAP)
            return;
        line_bytes++;
        if (b == CH_NUL)
        begin
            if (line_phase == PH_VALUE)
                push_value(8'h00, 1'b1, 1'b0);
            line_phase = PH_DONE;
            esc_seen   = 1'b0;
            return;
        end
        case (line_phase)
            PH_SEARCH:
            begin
                for (int i = WIN_DEPTH - 1; i > 0; i--)
                    recent_bytes[i] = recent_bytes[i-1];
                recent_bytes[0] = b;
                if (key_in_window())
                    line_phase = PH_COLON;
            end
            PH_COLON:
            begin
                if (b == CH_COLON)
                    line_phase = PH_SPACES;
            end
            PH_SPACES:
            begin
                if (b == CH_QUOTE)
                    line_phase = PH_VALUE;
                else if (b != CH_SPACE && b != CH_TAB)
                    line_phase = PH_DONE;
            end
            PH_VALUE:
            begin
                if (esc_seen)
                begin
                    esc_seen = 1'b0;
                    push_value((b == CH_LOWER_N) ? CH_LF : (b == CH_LOWER_T) ? CH_TAB : b,
                               1'b0, 1'b0);
                end
                else if (b == CH_BACKSLASH)
                    esc_seen = 1'b1;
                else if (b == CH_QUOTE)
                begin
                    push_value(8'h00, 1'b1, 1'b1);
                    line_phase = PH_DONE;
                end
                else
                    push_value(b, 1'b0, 1'b0);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Random byte with no framing or JSON meaning.
    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_LF || b == CH_QUOTE || b == CH_BACKSLASH || b == CH_COLON);
        return b;
    endfunction

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        for (int i = 0; i < KEY_MAX; i++)
            k[8*i +: 8] = rand_plain();
        return k;
    endfunction

    // Receiver: random stalls, or a long hold while rx_hold counts down.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
            m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each accepted value beat with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (value_fifo.size() == 0)
            begin
                $error("unexpected value beat: value_byte %h value_end %b value_good %b",
                       m_tdata, m_tlast, m_tuser[0]);
                errors++;
            end
            else
            begin
                want = value_fifo.pop_front();
                if (m_tlast !== want.last)
                begin
                    $error("value_end: expected %0b, got %0b", want.last, m_tlast);
                    errors++;
                end
                // The byte carries no meaning on an end marker.
                if (!want.last && m_tdata !== want.data)
                begin
                    $error("value_byte: expected %h, got %h", want.data, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.good)
                begin
                    $error("value_good: expected %0b, got %0b", want.good, m_tuser[0]);
                    errors++;
                end
                if (!want.last)
                    bytes_out++;
                else if (want.good)
                    good_ends++;
                else
                    aborted_ends++;
            end
        end
    end

    // Offer one input beat, with random idle cycles first, and wait for it to be taken.
    task automatic send_beat(input logic [7:0] b, input logic eos);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
        begin
            ready_low_cycles++;
            @(posedge clk);
        end
        parse_beat(b, eos);
        beats_in++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic send_filler(input int count);
        repeat (count)
            send_beat(rand_plain(), 1'b0);
    endtask

    // Stop offering beats, wait for every expected value beat, then let the pipe settle.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (value_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        if (idx == REG_KEY_CHARS)
            key_chars_q = v;
        else
            key_len_q = v[3:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_key(input logic [63:0] chars, input logic [3:0] len);
        quiesce();
        write_reg(REG_KEY_CHARS, chars);
        write_reg(REG_KEY_LENGTH, {60'd0, len});
    endtask

    // Build one line around the current key and send it. A broken line is cut short,
    // has a zero byte inserted or a byte corrupted, or is pure noise.
    task automatic send_json_line(input bit intact);
        int pos;
        int units;
        int pick;
        line_buf.delete();
        repeat ($urandom_range(0, 3))
            line_buf.push_back(rand_plain());
        line_buf.push_back(CH_QUOTE);
        for (int k = 0; k < key_span(); k++)
            line_buf.push_back(key_char(k));
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 2))
            line_buf.push_back(rand_plain());
        line_buf.push_back(CH_COLON);
        repeat ($urandom_range(0, 3))
            line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        line_buf.push_back(CH_QUOTE);
        units = $urandom_range(0, 8);
        repeat (units)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                line_buf.push_back(rand_plain());
            else
            begin
                line_buf.push_back(CH_BACKSLASH);
                case ($urandom_range(4))
                    0: line_buf.push_back(CH_QUOTE);
                    1: line_buf.push_back(CH_BACKSLASH);
                    2: line_buf.push_back(CH_LOWER_N);
                    3: line_buf.push_back(CH_LOWER_T);
                    default: line_buf.push_back(rand_plain());
                endcase
            end
        end
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3))
            line_buf.push_back(rand_plain());

        if (!intact)
        begin
            pos = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(3))
                0:
                begin
                    while (line_buf.size() > pos)
                        void'(line_buf.pop_back());
                end
                1: line_buf.insert(pos, CH_NUL);
                2: line_buf[pos] = 8'($urandom_range(1, 255));
                default:
                begin
                    line_buf.delete();
                    repeat ($urandom_range(1, 20))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end

        foreach (line_buf[i])
            if (line_buf[i] != CH_LF)
                send_beat(line_buf[i], 1'b0);
        if ($urandom_range(9) == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b1);
        else
            send_beat(CH_LF, 1'b0);
    endtask

    // Reset key, all escape forms, and the extreme byte values inside a value.
    task automatic test_reset_key();
        send_text("{\"message\":  \"Hi\\\"\\\\\\n\\t\\q\"}\n");
        send_text("\"message\"\t:\t\"");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h01, 1'b0);
        send_text("\"\n");
        quiesce();
    endtask

    // Line ends and zero bytes inside a value and after an escape, and end of stream inside a value.
    task automatic test_aborts();
        set_key(64'h6B, 4'd1);
        send_text("\"k\" : x\"no\"\n");
        send_text("\"k\":\"ab\n");
        send_text("\"k\":\"a\\\n");
        send_text("\"k\":\"a");
        send_beat(CH_NUL, 1'b0);
        send_text("\"k\":\"z\"\n");
        send_text("\"k\":\"\\");
        send_beat(CH_NUL, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_text("\"k\":\"ab");
        send_beat(CH_QUOTE, 1'b1);
        send_beat(CH_NUL, 1'b0);
        send_text("\"k\":\"v\"\n");
        send_text("\"k\":\"a\" \"k\":\"b\"\n");
        send_text("\"k\":\"\"\n");
        quiesce();
    endtask

    // A line longer than the capacity: a value cut at the limit, then a whole
    // key and value past it that must be dropped unseen.
    task automatic test_line_overflow();
        send_filler(2040);
        send_text("\"k\":\"xxxxxxxxxx\"k\":\"v\"\n");
        send_text("\"k\":\"ok\"\n");
        quiesce();
    endtask

    // Key register extremes and lengths below, inside and above the valid range.
    task automatic test_key_settings();
        logic [63:0] chars_set [6];
        logic [3:0]  len_set [6];
        chars_set[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        len_set[0]   = 4'd8;
        chars_set[1] = rand_key();
        len_set[1]   = 4'd0;
        chars_set[2] = rand_key();
        len_set[2]   = 4'd15;
        chars_set[3] = rand_key();
        len_set[3]   = 4'd9;
        chars_set[4] = rand_key();
        len_set[4]   = 4'd3;
        chars_set[5] = 64'h0;
        len_set[5]   = 4'd4;
        for (int s = 0; s < 6; s++)
        begin
            set_key(chars_set[s], len_set[s]);
            repeat (3)
                send_json_line(1'b1);
            send_json_line(1'b0);
        end
        quiesce();
    endtask

    // Receiver holds off for a long stretch while long values keep arriving.
    task automatic test_backpressure();
        set_key(64'h6B, 4'd1);
        idle_on = 1'b0;
        rx_hold = 300;
        repeat (3)
        begin
            send_text("\"k\":\"");
            send_filler(60);
            send_text("\"\n");
        end
        quiesce();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed lines with random content, new keys now and then,
    // and one stretch without any idle cycles.
    task automatic test_random_lines();
        int first;
        int done;
        int next_key;
        first    = beats_in;
        next_key = 0;
        done     = 0;
        while (done < RANDOM_BEATS)
        begin
            if (done >= next_key)
            begin
                set_key(rand_key(), 4'($urandom_range(0, 15)));
                next_key = done + 200;
            end
            idle_on = !(done >= 300 && done < 500);
            send_json_line($urandom_range(99) < 75);
            done = beats_in - first;
        end
        idle_on = 1'b1;
        quiesce();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = 8'h00;
        s_tlast          = 1'b0;
        m_tready         = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_KEY_CHARS;
        cfg_data         = 64'h0;
        idle_on          = 1'b1;
        rx_hold          = 0;
        errors           = 0;
        beats_in         = 0;
        bytes_out        = 0;
        good_ends        = 0;
        aborted_ends     = 0;
        ready_low_cycles = 0;
        key_chars_q      = KEY_CHARS_RESET;
        key_len_q        = KEY_LENGTH_RESET;
        clear_line_state();

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_aborts();
        test_line_overflow();
        test_key_settings();
        test_backpressure();
        test_random_lines();

        $display("Sent %0d input beats: escapes, aborts, overflow, key lengths 0..15, stalls.",
                 beats_in);
        $display("Checked %0d value bytes, %0d closed and %0d aborted values; %0d input stalls.",
                 bytes_out, good_ends, aborted_ends, ready_low_cycles);
        if (errors == 0)
            $display("** json_string_field_extractor_unit: PASSED **");
        else
            $display("** json_string_field_extractor_unit: FAILED **");
        $finish;
    end

endmodule

[sim.f]
sv/jsfe_pkg.sv
sv/jsfe_key_window.sv
sv/jsfe_parser.sv
sv/json_string_field_extractor_unit.sv
tb/sv/json_string_field_extractor_unit_test.sv
